>>> sv/kvs_pkg.sv
// Shared constants and types for the keyframe vector sampler.
`timescale 1ns / 1ps
package kvs_pkg;

  localparam int MAX_KEYS = 16;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  localparam int TIME_W     = 31;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 4;
  localparam int KCNT_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // restoring divider: 32 steps for the time wrap, 17 for the fraction
  localparam int MOD_STEPS = 32;
  localparam int FRAC_W    = 17;
  localparam int DCNT_W    = $clog2(MOD_STEPS + 1);
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam logic [KCNT_W-1:0] KEY_COUNT_RST = 5'd1;
  localparam logic [TIME_W-1:0] DURATION_RST  = 31'd65536;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COUNT = 2'd0,
    REG_DURATION  = 2'd1
  } cfg_reg_t;

  // v[0] = x, v[1] = y, v[2] = z
  typedef struct packed {
    logic [TIME_W-1:0]           t;
    logic [2:0][VAL_W-1:0]       v;
  } key_entry_t;

  localparam int KEY_W = $bits(key_entry_t);

endpackage

>>> sv/kvs_in_if.sv
// Input channel: keyframe writes and sample requests.
`timescale 1ns / 1ps
interface kvs_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [kvs_pkg::IDX_W-1:0]         key_index;
  logic [kvs_pkg::TIME_W-1:0]        key_time;
  logic signed [kvs_pkg::VAL_W-1:0]  key_x;
  logic signed [kvs_pkg::VAL_W-1:0]  key_y;
  logic signed [kvs_pkg::VAL_W-1:0]  key_z;
  logic signed [kvs_pkg::VAL_W-1:0]  delta_time;

  modport source (
    output valid, func, key_index, key_time, key_x, key_y, key_z, delta_time,
    input  ready
  );
  modport sink (
    input  valid, func, key_index, key_time, key_x, key_y, key_z, delta_time,
    output ready
  );
endinterface

>>> sv/kvs_out_if.sv
// Result channel: interpolated xyz and wrapped time.
`timescale 1ns / 1ps
interface kvs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kvs_pkg::VAL_W-1:0]  out_x;
  logic signed [kvs_pkg::VAL_W-1:0]  out_y;
  logic signed [kvs_pkg::VAL_W-1:0]  out_z;
  logic [kvs_pkg::TIME_W-1:0]        anim_time;

  modport source (
    output valid, out_x, out_y, out_z, anim_time,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, anim_time,
    output ready
  );
endinterface

>>> sv/kvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/keyframe_vector_sampler_unit.sv
// Keyframe table with time wrap, key search and linear xyz interpolation.
// Keyframe write: taken in one cycle, no result.
// Sample: 5 cycles (time before or at key 0, or one key) up to about 79 cycles:
//   2 for the time step, 32 more when the wrap needs the shared divider, one RAM
//   read per key searched, 18 for the fraction on the same divider, 9 for lerp.
// One item at a time; the result register frees the input while a result waits.
// Reset (synchronous, active low): time 0, key_count 1, duration 1.0; the key
//   table is not cleared and holds nothing until written.
`timescale 1ns / 1ps
module keyframe_vector_sampler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  kvs_in_if.sink                         in_ch,
  kvs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [kvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kvs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_WRAP, S_MOD, S_RD0, S_K0, S_SCAN,
    S_FINIT, S_FDIV, S_L_SUB, S_L_MUL, S_L_ADD, S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [KCNT_W-1:0]        key_count_r, key_count_nxt;
  logic [TIME_W-1:0]        duration_r, duration_nxt;
  logic [TIME_W-1:0]        anim_time_r, anim_time_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [DCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [VAL_W-1:0]         delta_r, delta_nxt;
  logic [VAL_W:0]           sum_r, sum_nxt;
  logic [TIME_W-1:0]        rem_r, rem_nxt;
  logic [VAL_W-1:0]         dvd_r, dvd_nxt;
  logic [FRAC_W-1:0]        q_r, q_nxt;
  logic [TIME_W-1:0]        div_d_r, div_d_nxt;
  key_entry_t               prev_r, prev_nxt;
  key_entry_t               hi_r, hi_nxt;
  logic [FRAC_W-1:0]        frac_r, frac_nxt;
  logic [1:0]               comp_r, comp_nxt;
  logic signed [VAL_W:0]    diff_r, diff_nxt;
  logic signed [VAL_W+FRAC_W+1:0] prod_r, prod_nxt;
  logic [2:0][VAL_W-1:0]    res_r, res_nxt;
  logic [VAL_W-1:0]         out_x_r, out_x_nxt;
  logic [VAL_W-1:0]         out_y_r, out_y_nxt;
  logic [VAL_W-1:0]         out_z_r, out_z_nxt;
  logic [TIME_W-1:0]        out_time_r, out_time_nxt;

  logic                     in_acc;
  logic                     ram_we;
  key_entry_t               ram_wdata;
  logic [KEY_W-1:0]         ram_rdata;
  key_entry_t               rd_e;
  logic [CNT_W-1:0]         n_eff;

  // shared divider step
  logic [VAL_W-1:0]         div_r2;
  logic                     div_ge;
  logic [TIME_W-1:0]        rem_step;
  logic [FRAC_W-1:0]        q_step;

  logic [VAL_W:0]           wsum;
  logic [TIME_W-1:0]        dt, dd;
  logic                     hit;
  logic [VAL_W-1:0]         lerp_a, lerp_b;
  logic signed [FRAC_W:0]   frac_s;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign ram_we = in_acc && (in_ch.func == FUNC_WRITE) && (32'(in_ch.key_index) < MAX_KEYS);
  assign ram_wdata.t = in_ch.key_time;
  assign ram_wdata.v = {in_ch.key_z, in_ch.key_y, in_ch.key_x};
  assign rd_e        = key_entry_t'(ram_rdata);

  kvs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (KEY_AW'(in_ch.key_index)),
    .wr_data (ram_wdata),
    .rd_addr (idx_r[KEY_AW-1:0]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    if (key_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(key_count_r) > MAX_KEYS) begin
      n_eff = CNT_W'(MAX_KEYS);
    end else begin
      n_eff = CNT_W'(key_count_r);
    end
  end

  assign div_r2   = {rem_r, dvd_r[VAL_W-1]};
  assign div_ge   = div_r2 >= {1'b0, div_d_r};
  assign rem_step = div_ge ? TIME_W'(div_r2 - {1'b0, div_d_r}) : div_r2[TIME_W-1:0];
  assign q_step   = {q_r[FRAC_W-2:0], div_ge};

  assign wsum   = sum_r + {2'b00, duration_r};
  assign dt     = anim_time_r - prev_r.t;
  assign dd     = hi_r.t - prev_r.t;
  assign hit    = (prev_r.t <= anim_time_r) && (anim_time_r <= rd_e.t);
  assign lerp_a = prev_r.v[comp_r];
  assign lerp_b = hi_r.v[comp_r];
  assign frac_s = {1'b0, frac_r};

  always_comb begin
    state_nxt     = state_r;
    key_count_nxt = key_count_r;
    duration_nxt  = duration_r;
    anim_time_nxt = anim_time_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    delta_nxt     = delta_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    q_nxt         = q_r;
    div_d_nxt     = div_d_r;
    prev_nxt      = prev_r;
    hi_nxt        = hi_r;
    frac_nxt      = frac_r;
    comp_nxt      = comp_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_time_nxt  = out_time_r;

    if (cfg_we) begin
      if (cfg_index == REG_KEY_COUNT) begin
        key_count_nxt = cfg_wdata[KCNT_W-1:0];
      end else if (cfg_index == REG_DURATION) begin
        duration_nxt = cfg_wdata[TIME_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.func == FUNC_SAMPLE) begin
          delta_nxt = in_ch.delta_time;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        sum_nxt   = {2'b00, anim_time_r} + {delta_r[VAL_W-1], delta_r};
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        idx_nxt   = '0;
        state_nxt = S_RD0;
        if (sum_r[VAL_W]) begin
          // negative: add the duration once, clamp at zero
          anim_time_nxt = wsum[VAL_W] ? '0 : wsum[TIME_W-1:0];
        end else if (duration_r == '0) begin
          anim_time_nxt = '0;
        end else if (sum_r[VAL_W-1:0] < {1'b0, duration_r}) begin
          anim_time_nxt = sum_r[TIME_W-1:0];
        end else begin
          rem_nxt   = '0;
          dvd_nxt   = sum_r[VAL_W-1:0];
          div_d_nxt = duration_r;
          cnt_nxt   = DCNT_W'(MOD_STEPS);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          anim_time_nxt = rem_step;
          state_nxt     = S_RD0;
        end
      end
      S_RD0: begin
        idx_nxt   = CNT_W'(1);
        state_nxt = S_K0;
      end
      S_K0: begin
        idx_nxt  = CNT_W'(2);
        prev_nxt = rd_e;
        if (n_eff == CNT_W'(1) || anim_time_r <= rd_e.t) begin
          res_nxt   = rd_e.v;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // read data is key idx_r-1, prev_r holds key idx_r-2
        if (hit) begin
          hi_nxt    = rd_e;
          state_nxt = S_FINIT;
        end else if (idx_r == n_eff) begin
          res_nxt   = rd_e.v;
          state_nxt = S_DONE;
        end else begin
          prev_nxt = rd_e;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      S_FINIT: begin
        comp_nxt = '0;
        if (dd == '0) begin
          frac_nxt  = '0;
          state_nxt = S_L_SUB;
        end else begin
          // dt <= dd, so (dt >> 1) < dd keeps the remainder invariant
          rem_nxt   = {1'b0, dt[TIME_W-1:1]};
          dvd_nxt   = {dt[0], {(VAL_W-1){1'b0}}};
          div_d_nxt = dd;
          q_nxt     = '0;
          cnt_nxt   = DCNT_W'(FRAC_W);
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
        q_nxt   = q_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          frac_nxt  = q_step;
          state_nxt = S_L_SUB;
        end
      end
      S_L_SUB: begin
        diff_nxt  = {lerp_b[VAL_W-1], lerp_b} - {lerp_a[VAL_W-1], lerp_a};
        state_nxt = S_L_MUL;
      end
      S_L_MUL: begin
        prod_nxt  = (VAL_W+FRAC_W+2)'(diff_r) * (VAL_W+FRAC_W+2)'(frac_s);
        state_nxt = S_L_ADD;
      end
      S_L_ADD: begin
        // floor of product / 2^16, kept to 32 bits
        res_nxt[comp_r] = lerp_a + prod_r[VAL_W+15:16];
        if (comp_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = S_L_SUB;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_x_nxt     = res_r[0];
          out_y_nxt     = res_r[1];
          out_z_nxt     = res_r[2];
          out_time_nxt  = anim_time_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    delta_r    <= delta_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    q_r        <= q_nxt;
    div_d_r    <= div_d_nxt;
    prev_r     <= prev_nxt;
    hi_r       <= hi_nxt;
    frac_r     <= frac_nxt;
    comp_r     <= comp_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_time_r <= out_time_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= KEY_COUNT_RST;
      duration_r  <= DURATION_RST;
      anim_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      duration_r  <= duration_nxt;
      anim_time_r <= anim_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.out_z     = out_z_r;
  assign out_ch.anim_time = out_time_r;

`ifndef SYNTHESIS
  a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_FDIV) |-> (rem_r < div_d_r))
    else $error("divider remainder not below divisor");

  a_frac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_L_MUL) |-> (frac_r <= FRAC_ONE))
    else $error("interpolation fraction above one");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented outside the done step");
`endif

endmodule
